// ===== sv/tslb_pkg.sv =====
// Package for the texture slot LRU binder.
// Holds the command codes, the result item layout and default parameter values.
// No dependencies.
`timescale 1ns / 1ps

package tslb_pkg;

    localparam int SLOTS_DEF       = 32;
    localparam int MAX_QUADS_DEF   = 1024;
    localparam int TEX_ID_BITS_DEF = 16;

    // Fixed widths of the result item fields.
    localparam int RES_SLOT_W = 5;
    localparam int RES_TEX_W  = 16;

    localparam int FUNC_W = 2;
    localparam logic [FUNC_W-1:0] FUNC_DRAW   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_UNLOAD = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_END    = 2'd2;

    typedef struct packed {
        logic [RES_SLOT_W-1:0] slot;
        logic                  slot_valid;
        logic                  was_resident;
        logic                  flush_before;
        logic                  evicted_valid;
        logic [RES_TEX_W-1:0]  evicted_texture;
    } tslb_result_t;

    // Lookup outcome; indices are five bits wide, enough for the default slot count.
    typedef struct packed {
        logic                  hit;
        logic [RES_SLOT_W-1:0] hit_idx;
        logic                  any_free;
        logic [RES_SLOT_W-1:0] free_idx;
        logic [RES_SLOT_W-1:0] victim_idx;
    } tslb_match_t;

endpackage

// ===== sv/tslb_if.sv =====
// Handshake interfaces of the texture slot LRU binder: command in, binding result out.
// Depends on tslb_pkg.
`timescale 1ns / 1ps

interface tslb_cmd_if
    import tslb_pkg::*;
#(
    parameter int ID_BITS = TEX_ID_BITS_DEF
);
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ID_BITS-1:0] texture_id;

    modport source (output valid, output func, output texture_id, input ready);
    modport sink   (input valid, input func, input texture_id, output ready);
endinterface

interface tslb_bind_if
    import tslb_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [RES_SLOT_W-1:0] slot;
    logic                  slot_valid;
    logic                  was_resident;
    logic                  flush_before;
    logic                  evicted_valid;
    logic [RES_TEX_W-1:0]  evicted_texture;

    modport source (output valid, output slot, output slot_valid, output was_resident,
                    output flush_before, output evicted_valid, output evicted_texture,
                    input ready);
    modport sink   (input valid, input slot, input slot_valid, input was_resident,
                    input flush_before, input evicted_valid, input evicted_texture,
                    output ready);
endinterface

// ===== sv/tslb_match.sv =====
// Parallel tag compare and slot selection for the texture slot LRU binder.
// Finds the hit slot, the lowest free slot and the least recently used slot.
// Depends on tslb_pkg.
`timescale 1ns / 1ps

module tslb_match
    import tslb_pkg::*;
#(
    parameter int SLOTS   = SLOTS_DEF,
    parameter int ID_BITS = TEX_ID_BITS_DEF
)(
    input  logic [ID_BITS-1:0]         owner [SLOTS],
    input  logic [SLOTS-1:0]           busy,
    input  logic [$clog2(SLOTS)-1:0]   age [SLOTS],
    input  logic [ID_BITS-1:0]         texture_id,
    output tslb_match_t                match
);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam logic [SLOT_W-1:0] AGE_LAST = SLOT_W'(SLOTS - 1);

    // Scanning downward leaves the lowest matching index in each encoder.
    always_comb
    begin
        match = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (busy[i] && owner[i] == texture_id)
            begin
                match.hit     = 1'b1;
                match.hit_idx = RES_SLOT_W'(i);
            end
            if (!busy[i])
            begin
                match.any_free = 1'b1;
                match.free_idx = RES_SLOT_W'(i);
            end
            // With every slot busy the ranks are a permutation, so the oldest is unique.
            if (age[i] == AGE_LAST)
            begin
                match.victim_idx = RES_SLOT_W'(i);
            end
        end
    end

endmodule

// ===== sv/tslb_core.sv =====
// Slot table, recency ranks and batch bookkeeping of the texture slot LRU binder.
// Computes one result and the next state per item in a single pass.
// Depends on tslb_pkg and tslb_match.
`timescale 1ns / 1ps

module tslb_core
    import tslb_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int MAX_QUADS = MAX_QUADS_DEF,
    parameter int ID_BITS   = TEX_ID_BITS_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic [FUNC_W-1:0]  func,
    input  logic [ID_BITS-1:0] texture_id,
    output tslb_result_t       result
);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int BCNT_W = $clog2(SLOTS + 1);
    localparam int QCNT_W = $clog2(MAX_QUADS + 1);
    localparam logic [SLOT_W-1:0] AGE_LAST  = SLOT_W'(SLOTS - 1);
    localparam logic [BCNT_W-1:0] BCNT_FULL = BCNT_W'(SLOTS);
    localparam logic [QCNT_W-1:0] QCNT_MAX  = QCNT_W'(MAX_QUADS);

    logic [ID_BITS-1:0] owner_reg [SLOTS];
    logic [SLOTS-1:0]   busy_reg, busy_next;
    logic [SLOT_W-1:0]  age_reg [SLOTS];
    logic [SLOT_W-1:0]  age_next [SLOTS];
    logic [SLOTS-1:0]   inb_reg, inb_next;
    logic [BCNT_W-1:0]  bcnt_reg, bcnt_next;
    logic [QCNT_W-1:0]  qcnt_reg, qcnt_next;

    tslb_match_t        match;
    logic [SLOT_W-1:0]  hit_s;
    logic [SLOT_W-1:0]  tgt;
    logic [SLOT_W-1:0]  cur_age;
    logic               is_new;
    logic               evict;
    logic               quad_flush;
    logic               slot_flush;
    logic               own_we;
    logic [SLOTS-1:0]   inb_base;
    logic [BCNT_W-1:0]  bcnt_base;
    logic [31:0]        ev_wide;

    tslb_match #(
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS)
    ) u_match (
        .owner      (owner_reg),
        .busy       (busy_reg),
        .age        (age_reg),
        .texture_id (texture_id),
        .match      (match)
    );

    assign hit_s   = match.hit_idx[SLOT_W-1:0];
    assign is_new  = !match.hit && match.any_free;
    assign evict   = !match.hit && !match.any_free;
    assign tgt     = match.hit ? hit_s :
                     (match.any_free ? match.free_idx[SLOT_W-1:0]
                                     : match.victim_idx[SLOT_W-1:0]);
    assign cur_age = age_reg[tgt];
    assign ev_wide = 32'(owner_reg[tgt]);

    // The quad-count flush empties the batch marks, so the slot flush cannot follow it.
    assign quad_flush = qcnt_reg >= QCNT_MAX;
    assign slot_flush = !match.hit && !quad_flush && bcnt_reg >= BCNT_FULL;
    assign inb_base   = (quad_flush || slot_flush) ? '0 : inb_reg;
    assign bcnt_base  = (quad_flush || slot_flush) ? '0 : bcnt_reg;

    always_comb
    begin
        busy_next = busy_reg;
        age_next  = age_reg;
        inb_next  = inb_reg;
        bcnt_next = bcnt_reg;
        qcnt_next = qcnt_reg;
        own_we    = 1'b0;
        result    = '0;
        case (func)
            FUNC_DRAW:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (busy_reg[i] && SLOT_W'(i) != tgt &&
                        (is_new ? (age_reg[i] != AGE_LAST) : (age_reg[i] < cur_age)))
                    begin
                        age_next[i] = age_reg[i] + 1'b1;
                    end
                end
                age_next[tgt]  = '0;
                busy_next[tgt] = 1'b1;
                own_we         = !match.hit;
                inb_next       = inb_base;
                inb_next[tgt]  = 1'b1;
                bcnt_next      = inb_base[tgt] ? bcnt_base : bcnt_base + 1'b1;
                qcnt_next      = quad_flush ? QCNT_W'(1) : qcnt_reg + 1'b1;

                result.slot            = RES_SLOT_W'(tgt);
                result.slot_valid      = 1'b1;
                result.was_resident    = match.hit;
                result.flush_before    = quad_flush || slot_flush;
                result.evicted_valid   = evict;
                result.evicted_texture = evict ? ev_wide[RES_TEX_W-1:0] : '0;
            end
            FUNC_UNLOAD:
            begin
                if (match.hit)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (busy_reg[i] && age_reg[i] > age_reg[hit_s])
                        begin
                            age_next[i] = age_reg[i] - 1'b1;
                        end
                    end
                    age_next[hit_s]     = '0;
                    busy_next[hit_s]    = 1'b0;
                    result.slot         = RES_SLOT_W'(hit_s);
                    result.slot_valid   = 1'b1;
                    result.was_resident = 1'b1;
                end
            end
            FUNC_END:
            begin
                inb_next            = '0;
                bcnt_next           = '0;
                qcnt_next           = '0;
                result.flush_before = 1'b1;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
            inb_reg  <= '0;
            bcnt_reg <= '0;
            qcnt_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else if (go)
        begin
            busy_reg <= busy_next;
            inb_reg  <= inb_next;
            bcnt_reg <= bcnt_next;
            qcnt_reg <= qcnt_next;
            age_reg  <= age_next;
        end
    end

    // Texture ids are read only where the slot is busy, so they need no reset.
    always_ff @(posedge clk)
    begin
        if (go && own_we)
        begin
            owner_reg[tgt] <= texture_id;
        end
    end

endmodule

// ===== sv/texture_slot_lru_binder.sv =====
// Texture slot LRU binder: maps texture ids to binding slots in LRU order with batch tracking.
// A command item waits in the input register, then its result is registered and offered.
// Throughput: one item per cycle without stalls, from the one-pass compare and rank update.
// Reset: rst_n clears every slot, rank, batch mark and count; no clearing pass is needed.
// Depends on tslb_pkg, tslb_if and tslb_core.
`timescale 1ns / 1ps

module texture_slot_lru_binder
    import tslb_pkg::*;
#(
    parameter int SLOTS           = SLOTS_DEF,
    parameter int MAX_QUADS       = MAX_QUADS_DEF,
    parameter int TEXTURE_ID_BITS = TEX_ID_BITS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    tslb_cmd_if.sink    cmd,
    tslb_bind_if.source binding
);
    logic                       in_valid_reg;
    logic [FUNC_W-1:0]          func_reg;
    logic [TEXTURE_ID_BITS-1:0] id_reg;
    logic                       out_valid_reg;
    tslb_result_t               res_reg;
    tslb_result_t               res_next;
    logic                       advance;
    logic                       go;

    // The result register moves whenever it is empty or being taken.
    assign advance   = !out_valid_reg || binding.ready;
    assign go        = in_valid_reg && advance;
    assign cmd.ready = !in_valid_reg || advance;

    tslb_core #(
        .SLOTS     (SLOTS),
        .MAX_QUADS (MAX_QUADS),
        .ID_BITS   (TEXTURE_ID_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .func       (func_reg),
        .texture_id (id_reg),
        .result     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (go)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            func_reg <= cmd.func;
            id_reg   <= TEXTURE_ID_BITS'(cmd.texture_id);
        end
        if (go)
        begin
            res_reg <= res_next;
        end
    end

    assign binding.valid           = out_valid_reg;
    assign binding.slot            = res_reg.slot;
    assign binding.slot_valid      = res_reg.slot_valid;
    assign binding.was_resident    = res_reg.was_resident;
    assign binding.flush_before    = res_reg.flush_before;
    assign binding.evicted_valid   = res_reg.evicted_valid;
    assign binding.evicted_texture = res_reg.evicted_texture;

endmodule

// ===== sim/tslb_binding_checker.sv =====
// Checker for the texture slot LRU binder: watches the command and binding channels,
// predicts each binding result and compares it field by field.
// Depends on tslb_pkg and the handshake interfaces in tslb_if.
`timescale 1ns / 1ps

module tslb_binding_checker
    import tslb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tslb_cmd_if  cmd_mon,
    tslb_bind_if res_mon,
    output int   fail_count,
    output int   outstanding
);

    localparam int NUM_SLOTS  = SLOTS_DEF;
    localparam int QUAD_LIMIT = MAX_QUADS_DEF;

    // Shadow copy of the binding table and the batch bookkeeping.
    logic [TEX_ID_BITS_DEF-1:0] slot_tex    [NUM_SLOTS];
    logic                       slot_held   [NUM_SLOTS];
    logic [RES_SLOT_W-1:0]      slot_rank   [NUM_SLOTS];
    logic                       slot_marked [NUM_SLOTS];
    int                         marked_count;
    int                         quad_count;

    tslb_result_t expected_bindings[$];
    tslb_result_t oldest;
    tslb_result_t predicted;

    function automatic void clear_batch();
        int i;
        for (i = 0; i < NUM_SLOTS; i++)
            slot_marked[i] = 1'b0;
        marked_count = 0;
        quad_count   = 0;
    endfunction

    function automatic int find_binding(input logic [TEX_ID_BITS_DEF-1:0] id);
        int i;
        for (i = 0; i < NUM_SLOTS; i++)
            if (slot_held[i] && slot_tex[i] == id)
                return i;
        return -1;
    endfunction

    // Slots more recent than the touched one age by a step; the touched one becomes newest.
    function automatic void refresh_recency(input int s, input int cur);
        int i;
        for (i = 0; i < NUM_SLOTS; i++)
            if (i != s && slot_held[i] && slot_rank[i] < cur && slot_rank[i] < NUM_SLOTS - 1)
                slot_rank[i] = slot_rank[i] + 1'b1;
        slot_rank[s] = '0;
    endfunction

    function automatic tslb_result_t bind_texture(input logic [FUNC_W-1:0] op,
                                                  input logic [TEX_ID_BITS_DEF-1:0] id);
        tslb_result_t r;
        int s;
        int i;
        int top_rank;
        logic [RES_SLOT_W-1:0] gone_rank;
        r = '0;
        s = -1;
        case (op)
            FUNC_DRAW:
            begin
                if (quad_count >= QUAD_LIMIT)
                begin
                    clear_batch();
                    r.flush_before = 1'b1;
                end
                s = find_binding(id);
                if (s >= 0)
                begin
                    r.was_resident = 1'b1;
                    refresh_recency(s, slot_rank[s]);
                end
                else
                begin
                    if (marked_count >= NUM_SLOTS)
                    begin
                        clear_batch();
                        r.flush_before = 1'b1;
                    end
                    for (i = 0; i < NUM_SLOTS && s < 0; i++)
                        if (!slot_held[i])
                            s = i;
                    if (s < 0)
                    begin
                        // Every slot is bound: the victim is the lowest slot of the oldest rank.
                        top_rank = 0;
                        for (i = 0; i < NUM_SLOTS; i++)
                            if (slot_rank[i] > top_rank)
                                top_rank = slot_rank[i];
                        for (i = NUM_SLOTS - 1; i >= 0; i--)
                            if (slot_rank[i] == top_rank)
                                s = i;
                        r.evicted_valid   = 1'b1;
                        r.evicted_texture = slot_tex[s];
                        refresh_recency(s, slot_rank[s]);
                    end
                    else
                    begin
                        slot_held[s] = 1'b1;
                        refresh_recency(s, NUM_SLOTS);
                    end
                    slot_tex[s] = id;
                end
                if (!slot_marked[s])
                begin
                    slot_marked[s] = 1'b1;
                    marked_count++;
                end
                quad_count++;
                r.slot       = RES_SLOT_W'(s);
                r.slot_valid = 1'b1;
            end
            FUNC_UNLOAD:
            begin
                s = find_binding(id);
                if (s >= 0)
                begin
                    gone_rank    = slot_rank[s];
                    slot_held[s] = 1'b0;
                    slot_rank[s] = '0;
                    for (i = 0; i < NUM_SLOTS; i++)
                        if (slot_held[i] && slot_rank[i] > gone_rank)
                            slot_rank[i] = slot_rank[i] - 1'b1;
                    r.slot         = RES_SLOT_W'(s);
                    r.slot_valid   = 1'b1;
                    r.was_resident = 1'b1;
                end
            end
            FUNC_END:
            begin
                clear_batch();
                r.flush_before = 1'b1;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_tex[i]  = '0;
                slot_held[i] = 1'b0;
                slot_rank[i] = '0;
            end
            clear_batch();
            expected_bindings.delete();
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (res_mon.valid && res_mon.ready)
            begin
                if (expected_bindings.size() == 0)
                begin
                    $error("binding result item arrived with no command waiting for it");
                    fail_count++;
                end
                else
                begin
                    oldest = expected_bindings.pop_front();
                    check_field("slot", 16'(oldest.slot), 16'(res_mon.slot));
                    check_field("slot_valid", 16'(oldest.slot_valid), 16'(res_mon.slot_valid));
                    check_field("was_resident", 16'(oldest.was_resident),
                                16'(res_mon.was_resident));
                    check_field("flush_before", 16'(oldest.flush_before),
                                16'(res_mon.flush_before));
                    check_field("evicted_valid", 16'(oldest.evicted_valid),
                                16'(res_mon.evicted_valid));
                    check_field("evicted_texture", 16'(oldest.evicted_texture),
                                16'(res_mon.evicted_texture));
                end
            end
            if (cmd_mon.valid && cmd_mon.ready)
            begin
                predicted = bind_texture(cmd_mon.func, cmd_mon.texture_id);
                expected_bindings.insert(expected_bindings.size(), predicted);
            end
            outstanding <= expected_bindings.size();
        end
    end

endmodule

// ===== sim/tb_texture_slot_lru_binder.sv =====
// Testbench top for the texture slot LRU binder: clock, reset, command stimulus,
// result back-pressure and the verdict.
// Depends on tslb_pkg, tslb_if, the binder RTL and tslb_binding_checker.
`timescale 1ns / 1ps

module tb_texture_slot_lru_binder;
    import tslb_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;
    localparam int LIMIT_CYCLES = 400000;
    localparam int POOL_A       = 40;
    localparam int POOL_B       = SLOTS_DEF;
    localparam int HIT_RUN      = MAX_QUADS_DEF - POOL_B;
    localparam int MIXED_ITEMS  = 260;
    localparam int TAIL_ITEMS   = 30;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   outstanding;
    int   cycle_count = 0;
    int   gap_pct;
    int   stall_pct;

    logic [15:0] pool_a [POOL_A];
    logic [15:0] pool_b [POOL_B];

    tslb_cmd_if  cmd_ch ();
    tslb_bind_if res_ch ();

    texture_slot_lru_binder dut (clk, rst_n, cmd_ch, res_ch);

    tslb_binding_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_mon     (cmd_ch),
        .res_mon     (res_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("FAIL texture_slot_lru_binder");
            $finish;
        end
    end

    // Result side back-pressure in random bursts.
    initial
    begin
        res_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 99) < stall_pct)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_cmd(input logic [FUNC_W-1:0] op, input logic [15:0] id);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < gap_pct)
            gap = $urandom_range(1, 16);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.func       <= op;
        cmd_ch.texture_id <= id;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
    endtask

    task automatic wait_results_drained();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic pick_idle_rates();
        case ($urandom_range(0, 3))
            0: gap_pct = 0;
            1: gap_pct = 10;
            2: gap_pct = 30;
            default: gap_pct = 60;
        endcase
        case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 3;
            2: stall_pct = 10;
            default: stall_pct = 25;
        endcase
    endtask

    // Mostly draws over a working set a bit larger than the slot count, so that
    // evictions and full-batch flushes happen; ends are rare to let the batch fill.
    task automatic send_mixed_item();
        int pick;
        logic [15:0] id;
        pick = $urandom_range(0, 99);
        id = pool_a[$urandom_range(0, POOL_A - 1)];
        if ($urandom_range(0, 9) == 0)
            id = 16'($urandom);
        if (pick < 72)
            send_cmd(FUNC_DRAW, id);
        else if (pick < 88)
            send_cmd(FUNC_UNLOAD, id);
        else if (pick < 90)
            send_cmd(FUNC_END, 16'($urandom));
        else if (pick < 93)
            send_cmd(FUNC_UNKNOWN, 16'($urandom));
        else
            send_cmd(FUNC_DRAW, 16'($urandom));
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.func       <= FUNC_DRAW;
        cmd_ch.texture_id <= '0;
        gap_pct   = 0;
        stall_pct = 0;
        for (int i = 0; i < POOL_A; i++)
            pool_a[i] = 16'($urandom);
        // Distinct ids with the top bit clear; ids with it set are sure misses later.
        for (int i = 0; i < POOL_B; i++)
            pool_b[i] = {1'b0, 10'($urandom), 5'(i)};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: empty flush, unknown code, unload misses, hits,
        // unload of a slot still marked in the batch and its reuse.
        send_cmd(FUNC_END, 16'h0000);
        send_cmd(FUNC_UNKNOWN, 16'hFFFF);
        send_cmd(FUNC_UNLOAD, 16'h1234);
        send_cmd(FUNC_DRAW, 16'h0000);
        send_cmd(FUNC_DRAW, 16'hFFFF);
        send_cmd(FUNC_DRAW, 16'h0000);
        send_cmd(FUNC_UNKNOWN, 16'h0000);
        send_cmd(FUNC_UNLOAD, 16'hFFFF);
        send_cmd(FUNC_DRAW, 16'hAAAA);
        send_cmd(FUNC_DRAW, 16'h5555);
        send_cmd(FUNC_UNLOAD, 16'h0000);
        send_cmd(FUNC_END, 16'hFFFF);
        send_cmd(FUNC_UNLOAD, 16'h0000);
        send_cmd(FUNC_DRAW, 16'h0000);
        send_cmd(FUNC_DRAW, 16'hFFFF);

        for (int n = 0; n < MIXED_ITEMS; n++)
        begin
            if (n % 50 == 0 && n != 0)
                pick_idle_rates();
            send_mixed_item();
        end

        wait_results_drained();

        // Fill every slot within one batch, then keep hitting until the quad limit
        // is reached; the closing miss meets both flush conditions at once.
        pick_idle_rates();
        send_cmd(FUNC_END, 16'($urandom));
        for (int i = 0; i < POOL_B; i++)
            send_cmd(FUNC_DRAW, pool_b[i]);
        for (int n = 0; n < HIT_RUN; n++)
        begin
            if (n == HIT_RUN - 200)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            if ($urandom_range(0, 99) < 3)
                send_cmd(FUNC_UNKNOWN, 16'($urandom));
            send_cmd(FUNC_DRAW, pool_b[$urandom_range(0, POOL_B - 1)]);
        end
        send_cmd(FUNC_DRAW, {1'b1, 15'($urandom)});

        for (int n = 0; n < TAIL_ITEMS; n++)
            send_mixed_item();

        wait_results_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS texture_slot_lru_binder");
        else
            $display("FAIL texture_slot_lru_binder");
        $finish;
    end

endmodule
